### sv/cbth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbth_pkg
// Shared types and constants of the chained block token hash unit.
// ----------------------------------------------------------------------------
package cbth_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned HALF_W  = 32;
   localparam int unsigned BSIZE_W = 13;
   localparam int unsigned COUNT_W = 12;
   localparam int unsigned BLOCK_W = 16;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned PHASE_W = 2;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 13'd16;
   localparam logic [BSIZE_W-1:0] BSIZE_MAX   = 13'd4096;

   localparam logic [ADDR_W-1:0] REG_SALT  = 4'h0;
   localparam logic [ADDR_W-1:0] REG_BSIZE = 4'h8;

   typedef enum logic [OP_W-1:0] {
      OP_TOKEN  = 3'd0,
      OP_FOLD_1 = 3'd1,
      OP_FOLD_2 = 3'd2,
      OP_FIN_1  = 3'd3,
      OP_FIN_2  = 3'd4
   } mul_op_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_LO_LO = 2'd0,
      PH_HI_LO = 2'd1,
      PH_LO_HI = 2'd2
   } mul_phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_MUL  = 2'b10
   } state_type;

   function automatic logic [WORD_W-1:0] mul_const(input mul_op_type op);
      logic [WORD_W-1:0] c;
      unique case (op)
         OP_TOKEN:  c = 64'h9e3779b97f4a7c15;
         OP_FOLD_1: c = 64'hbf58476d1ce4e5b9;
         OP_FOLD_2: c = 64'h94d049bb133111eb;
         OP_FIN_1:  c = 64'hff51afd7ed558ccd;
         OP_FIN_2:  c = 64'hc4ceb9fe1a85ec53;
         default:   c = '0;
      endcase
      return c;
   endfunction

endpackage

### sv/chained_block_token_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_block_token_hash_unit
// Folds 64-bit tokens into a chained per-block hash and finalizes each full
// block with the salt, using one shared 32x32 multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// req      in   req_valid/ready    token, restart, resume_block, resume_hash
// rsp      out  rsp_valid/ready    chain_hash, block_number
// csr      in   APB, pready high   salt @0x0, block length @0x8 (64-bit data)
//
// Every 64-bit product is three 32x32 partial products through the single
// multiplier, three products per fold and two more per block finalization.
// req_ready is low while a token is in the multiplier sequence.
// A finished hash waits in the output register; a following block end holds
// until that register is taken. Reset is synchronous; it resets control state,
// accumulator, salt and block length, not operand, product or output data.
// ----------------------------------------------------------------------------
module chained_block_token_hash_unit
   import cbth_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [WORD_W-1:0]   req_token,
   input  logic                req_restart,
   input  logic [BLOCK_W-1:0]  req_resume_block,
   input  logic [WORD_W-1:0]   req_resume_hash,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_chain_hash,
   output logic [BLOCK_W-1:0]  rsp_block_number,

   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [ADDR_W-1:0]   csr_paddr,
   input  logic [WORD_W-1:0]   csr_pwdata,
   output logic [WORD_W-1:0]   csr_prdata,
   output logic                csr_pready
);

   state_type            state_ff, state_in;
   mul_op_type           op_ff, op_in;
   mul_phase_type        phase_ff, phase_in;
   logic [WORD_W-1:0]    opa_ff, opa_in;
   logic [WORD_W-1:0]    prod_ff, prod_in;
   logic [WORD_W-1:0]    acc_ff, acc_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [BLOCK_W-1:0]   block_ff, block_in;
   logic [WORD_W-1:0]    salt_ff;
   logic [BSIZE_W-1:0]   bsize_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]    rsp_hash_ff, rsp_hash_in;
   logic [BLOCK_W-1:0]   rsp_block_ff, rsp_block_in;

   logic                 req_xfer;
   logic                 csr_wr;
   logic                 out_free;
   logic [WORD_W-1:0]    b_const;
   logic [HALF_W-1:0]    mul_a, mul_b;
   logic [WORD_W-1:0]    mul_p;
   logic [WORD_W-1:0]    mres;
   logic [WORD_W-1:0]    z, folded, fin_x;
   logic [BSIZE_W-1:0]   eff_size;
   logic [BSIZE_W-1:0]   count_inc;
   logic                 block_done;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[3] ? {{(WORD_W-BSIZE_W){1'b0}}, bsize_ff} : salt_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chain_hash   = rsp_hash_ff;
   assign rsp_block_number = rsp_block_ff;
   assign out_free         = !rsp_valid_ff || rsp_ready;

   assign b_const = mul_const(op_ff);

   always_comb begin
      unique case (phase_ff)
         PH_LO_LO: begin
            mul_a = opa_ff[HALF_W-1:0];
            mul_b = b_const[HALF_W-1:0];
         end
         PH_HI_LO: begin
            mul_a = opa_ff[WORD_W-1:HALF_W];
            mul_b = b_const[HALF_W-1:0];
         end
         PH_LO_HI: begin
            mul_a = opa_ff[HALF_W-1:0];
            mul_b = b_const[WORD_W-1:HALF_W];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   assign mres  = prod_ff + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};

   assign z      = acc_ff ^ mres;
   assign folded = mres ^ (mres >> 31);
   assign fin_x  = folded ^ salt_ff;

   always_comb begin
      if (bsize_ff == '0) begin
         eff_size = {{(BSIZE_W-1){1'b0}}, 1'b1};
      end else if (bsize_ff > BSIZE_MAX) begin
         eff_size = BSIZE_MAX;
      end else begin
         eff_size = bsize_ff;
      end
   end

   assign count_inc  = {1'b0, count_ff} + {{(BSIZE_W-1){1'b0}}, 1'b1};
   assign block_done = (count_inc >= eff_size);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      opa_in       = opa_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      block_in     = block_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_block_in = rsp_block_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_MUL;
               op_in    = OP_TOKEN;
               phase_in = PH_LO_LO;
               opa_in   = req_token;
               if (req_restart) begin
                  acc_in   = (req_resume_block == '0) ? salt_ff : req_resume_hash;
                  block_in = req_resume_block;
                  count_in = '0;
               end
            end
         end
         ST_MUL: begin
            unique case (phase_ff)
               PH_LO_LO: begin
                  prod_in  = mul_p;
                  phase_in = PH_HI_LO;
               end
               PH_HI_LO: begin
                  prod_in  = mres;
                  phase_in = PH_LO_HI;
               end
               PH_LO_HI: begin
                  phase_in = PH_LO_LO;
                  unique case (op_ff)
                     OP_TOKEN: begin
                        opa_in = z ^ (z >> 30);
                        op_in  = OP_FOLD_1;
                     end
                     OP_FOLD_1: begin
                        opa_in = mres ^ (mres >> 27);
                        op_in  = OP_FOLD_2;
                     end
                     OP_FOLD_2: begin
                        acc_in = folded;
                        if (block_done) begin
                           opa_in = fin_x ^ (fin_x >> 33);
                           op_in  = OP_FIN_1;
                        end else begin
                           count_in = count_inc[COUNT_W-1:0];
                           state_in = ST_IDLE;
                        end
                     end
                     OP_FIN_1: begin
                        opa_in = mres ^ (mres >> 33);
                        op_in  = OP_FIN_2;
                     end
                     OP_FIN_2: begin
                        if (out_free) begin
                           acc_in       = mres ^ (mres >> 33);
                           rsp_valid_in = 1'b1;
                           rsp_hash_in  = mres ^ (mres >> 33);
                           rsp_block_in = block_ff;
                           count_in     = '0;
                           block_in     = block_ff + {{(BLOCK_W-1){1'b0}}, 1'b1};
                           state_in     = ST_IDLE;
                        end else begin
                           phase_in = PH_LO_HI;
                        end
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
               default: begin
                  phase_in = PH_LO_LO;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_TOKEN;
         phase_ff     <= PH_LO_LO;
         acc_ff       <= '0;
         count_ff     <= '0;
         block_ff     <= '0;
         salt_ff      <= '0;
         bsize_ff     <= BSIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         block_ff     <= block_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            if (csr_paddr[3]) begin
               bsize_ff <= csr_pwdata[BSIZE_W-1:0];
            end else begin
               salt_ff <= csr_pwdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      opa_ff       <= opa_in;
      prod_ff      <= prod_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_block_ff <= rsp_block_in;
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> !req_ready)
      else $error("req_ready high during multiplier sequence");

   a_xfer_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_MUL && op_ff == OP_TOKEN && phase_ff == PH_LO_LO))
      else $error("token transfer did not start the fold sequence");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LO_LO || phase_ff == PH_HI_LO || phase_ff == PH_LO_HI))
      else $error("illegal multiplier phase");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_hash_ff)
                                       && $stable(rsp_block_ff)))
      else $error("pending result overwritten");

   a_block_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && op_ff == OP_FIN_2 && phase_ff == PH_LO_HI && out_free)
      |=> (block_ff == $past(block_ff) + {{(BLOCK_W-1){1'b0}}, 1'b1}
           && rsp_block_ff == $past(block_ff)))
      else $error("block index did not advance on block end");

endmodule
